// File: hdl/crcfq_pkg.sv
package crcfq_pkg;

  // frame buffer geometry
  localparam int FRAME_BYTES = 64;
  localparam int QUEUE_SLOTS = 4;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
  localparam int ADDR_W      = SLOT_W + POS_W;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int LEN_W       = 6;

  // header is five bytes, check value two
  localparam int HDR_BYTES   = 5;
  localparam int CHK_BYTES   = 2;
  localparam int ACK_POS     = 3;
  localparam int LEN_POS     = 4;

  // result queue
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_IDX_W    = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    FN_BYTE = 2'd0,
    FN_IDLE = 2'd1,
    FN_READ = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_BAD      = 3'd3,
    ST_ACCEPTED = 3'd4,
    ST_FULL     = 3'd5,
    ST_READ     = 3'd6,
    ST_EMPTY    = 3'd7
  } status_t;

  typedef struct packed {
    status_t          status;
    logic             ack;
    logic             last;
    logic [LEN_W-1:0] len;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    res_t       res;
    logic [7:0] rbyte;
  } oq_item_t;

  // one byte of crc-16, msb first, no reflection
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/crcfq_store.sv
module crcfq_store import crcfq_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [FRAME_BYTES*QUEUE_SLOTS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/crcfq_front.sv
module crcfq_front import crcfq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [1:0] func,
  input  logic [7:0] rx_byte,
  output mem_req_t   mem_req,
  output logic       res_valid,
  output res_t       res
);

  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [POS_W-1:0]  read_pos_r, read_pos_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              ack_one_r, ack_one_nxt;
  logic [7:0]        length_byte_r, length_byte_nxt;
  logic [15:0]       rcheck_r, rcheck_nxt;
  logic [LEN_W-1:0]  slot_len_r [QUEUE_SLOTS];
  logic              slot_we;
  logic [LEN_W-1:0]  slot_wlen;
  logic              res_valid_r;
  res_t              res_r, res_nxt;

  logic [8:0]        ck;
  logic [8:0]        idx;
  logic [8:0]        flen;
  logic [LEN_W-1:0]  rd_len;
  logic              rd_last;
  func_t             fn;

  assign fn     = func_t'(func);
  assign idx    = 9'(byte_count_r);
  assign flen   = {1'b0, length_byte_r} + 9'(HDR_BYTES);
  assign rd_len = slot_len_r[read_slot_r];
  assign rd_last = ({1'b0, read_pos_r} + 7'd1) >= {1'b0, rd_len};

  always_comb begin
    write_slot_nxt  = write_slot_r;
    read_slot_nxt   = read_slot_r;
    read_pos_nxt    = read_pos_r;
    byte_count_nxt  = byte_count_r;
    crc_nxt         = crc_r;
    ack_one_nxt     = ack_one_r;
    length_byte_nxt = length_byte_r;
    rcheck_nxt      = rcheck_r;
    slot_we         = 1'b0;
    slot_wlen       = flen[LEN_W-1:0];
    mem_req         = '0;
    res_nxt         = '{status: ST_IGNORED, ack: 1'b0, last: 1'b0, len: '0};
    ck              = flen;
    if (fire) begin
      unique case (fn)
        FN_BYTE: begin
          if (byte_count_r >= CNT_W'(FRAME_BYTES)) begin
            res_nxt.status = ST_DROPPED;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = {write_slot_r, byte_count_r[POS_W-1:0]};
            mem_req.wdata = rx_byte;
            if (idx == 9'(ACK_POS)) begin
              ack_one_nxt = (rx_byte == 8'd1);
            end
            if (idx == 9'(LEN_POS)) begin
              length_byte_nxt = rx_byte;
              ck = {1'b0, rx_byte} + 9'(HDR_BYTES);
            end
            if (idx < 9'(HDR_BYTES) || idx < ck) begin
              crc_nxt = crc_step(crc_r, rx_byte);
            end else if (idx == ck) begin
              rcheck_nxt[15:8] = rx_byte;
            end else if (idx == ck + 9'd1) begin
              rcheck_nxt[7:0] = rx_byte;
            end
            byte_count_nxt = byte_count_r + 1'b1;
            res_nxt.status = ST_STORED;
          end
        end
        FN_IDLE: begin
          priority if (byte_count_r < CNT_W'(HDR_BYTES)) begin
            res_nxt.status = ST_BAD;
          end else if (!ack_one_r && length_byte_r <= 8'd1) begin
            res_nxt.status = ST_IGNORED;
          end else if (flen + 9'(CHK_BYTES) > 9'(FRAME_BYTES) ||
                       idx < flen + 9'(CHK_BYTES)) begin
            res_nxt.status = ST_BAD;
          end else if (rcheck_r != crc_r) begin
            res_nxt.status = ST_BAD;
          end else if (write_slot_r + 1'b1 == read_slot_r) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.status = ST_ACCEPTED;
            res_nxt.ack    = ack_one_r;
            res_nxt.len    = flen[LEN_W-1:0];
            slot_we        = 1'b1;
            write_slot_nxt = write_slot_r + 1'b1;
          end
          byte_count_nxt  = '0;
          crc_nxt         = '0;
          ack_one_nxt     = 1'b0;
          length_byte_nxt = '0;
          rcheck_nxt      = '0;
        end
        FN_READ: begin
          if (write_slot_r == read_slot_r) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            mem_req.re     = 1'b1;
            mem_req.raddr  = {read_slot_r, read_pos_r};
            res_nxt.status = ST_READ;
            res_nxt.last   = rd_last;
            res_nxt.len    = rd_len;
            if (rd_last) begin
              read_pos_nxt  = '0;
              read_slot_nxt = read_slot_r + 1'b1;
            end else begin
              read_pos_nxt = read_pos_r + 1'b1;
            end
          end
        end
        FN_NONE: begin
          res_nxt.status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r  <= '0;
      read_slot_r   <= '0;
      read_pos_r    <= '0;
      byte_count_r  <= '0;
      crc_r         <= '0;
      ack_one_r     <= 1'b0;
      length_byte_r <= '0;
      rcheck_r      <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      write_slot_r  <= write_slot_nxt;
      read_slot_r   <= read_slot_nxt;
      read_pos_r    <= read_pos_nxt;
      byte_count_r  <= byte_count_nxt;
      crc_r         <= crc_nxt;
      ack_one_r     <= ack_one_nxt;
      length_byte_r <= length_byte_nxt;
      rcheck_r      <= rcheck_nxt;
      res_valid_r   <= fire;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (slot_we) begin
      slot_len_r[write_slot_r] <= slot_wlen;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // an accepted frame never lets the ring wrap onto the read side
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |=> write_slot_r != read_slot_r)
    else $error("write slot caught up with read slot");

  // accepted frames fit the slot with their check value
  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.status == ST_ACCEPTED |->
      32'(res_r.len) + CHK_BYTES <= FRAME_BYTES)
    else $error("accepted frame longer than slot");

  // a read result is only produced while the ring held a frame
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.re |-> write_slot_r != read_slot_r && !mem_req.we)
    else $error("read issued on empty ring");

endmodule

// File: hdl/crcfq_outq.sv
module crcfq_outq import crcfq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_t       res,
  input  logic [7:0] rdata,
  output logic       space_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output oq_item_t   head
);

  oq_item_t              q_r [OQ_DEPTH];
  logic [OQ_IDX_W-1:0]   wr_idx_r, rd_idx_r;
  logic [OQ_CNT_W-1:0]   count_r;
  logic                  pop;
  oq_item_t              item;

  assign pop        = out_valid && out_ready;
  assign out_valid  = count_r != '0;
  assign head       = q_r[rd_idx_r];
  assign item.res   = res;
  assign item.rbyte = (res.status == ST_READ) ? rdata : 8'd0;
  // credit covers the item still in the front register
  assign space_ok   = (count_r + OQ_CNT_W'(push)) < OQ_CNT_W'(OQ_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_idx_r <= wr_idx_r + 1'b1;
      end
      if (pop) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      count_r <= count_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r < OQ_CNT_W'(OQ_DEPTH) || pop)
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("result count lost a push");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result count out of range");

endmodule

// File: hdl/crc_checked_frame_receive_queue.sv
// crc-checked frame receiver with a queue of frames. each input word is one
// event: a received byte, a line-idle that closes the frame, or a read of the
// next queued byte. byte 3 of a frame is the acknowledge flag, byte 4 the
// payload length l; the crc-16 (poly 0x1021, init 0, msb first) covers bytes
// 0..l+4 and bytes l+5, l+6 hold the check value, high byte first. a good
// frame keeps its first l+5 bytes in one of four 64-byte slots; the ring
// holds at most three frames. every input word gives exactly one result
// word. one input word is taken per clock while the result queue has space;
// each result is registered in the front stage, alongside the registered
// frame-buffer read, then written into a four-entry result queue, so input
// keeps flowing while the consumer stalls until that queue fills.
// no clearing pass is needed after reset.
module crc_checked_frame_receive_queue import crcfq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic       out_ack_request,
  output logic [7:0] out_read_byte,
  output logic       out_read_last,
  output logic [5:0] out_frame_length
);

  logic     fire;
  mem_req_t mem_req;
  logic     res_valid;
  res_t     res;
  logic [7:0] rdata;
  logic     space_ok;
  oq_item_t head;

  // input word accepted
  assign fire     = in_valid && in_ready;
  assign in_ready = space_ok;

  // front: frame state, crc, ring pointers and classification
  crcfq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .func      (in_func),
    .rx_byte   (in_rx_byte),
    .mem_req   (mem_req),
    .res_valid (res_valid),
    .res       (res)
  );

  // frame buffer, one write and one registered read per clock
  crcfq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // back: merges read data and queues results for the consumer
  crcfq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .res       (res),
    .rdata     (rdata),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_status       = head.res.status;
  assign out_ack_request  = head.res.ack;
  assign out_read_byte    = head.rbyte;
  assign out_read_last    = head.res.last;
  assign out_frame_length = head.res.len;

endmodule
